// File: sv/transport_counter_restamper_macros.svh
// ----------------------------------------------------------------------------
// transport counter restamper assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TRANSPORT_COUNTER_RESTAMPER_MACROS_SVH
`define TRANSPORT_COUNTER_RESTAMPER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/tcr_pkg.sv
// ----------------------------------------------------------------------------
// tcr_pkg
// request types and fixed constants of the transport counter restamper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcr_pkg;

	// largest record length accepted as well formed
	localparam int unsigned MAX_RECORD_BYTES = 256;

	// frame header walk positions
	localparam logic [2:0] HDR_LEN_LO  = 3'd0;
	localparam logic [2:0] HDR_LEN_HI  = 3'd1;
	localparam logic [2:0] HDR_CNT_LO  = 3'd2;
	localparam logic [2:0] HDR_CNT_HI  = 3'd3;
	localparam logic [2:0] HDR_PAYLOAD = 3'd4;

	// frame header is four bytes
	localparam logic [9:0] HDR_BYTES = 10'd4;

	// byte offset saturates here
	localparam logic [8:0] OFFSET_MAX = 9'h1FF;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [8:0] record_length;
		logic       first_of_record;
		logic       last_of_record;
		logic       new_session;
	} in_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_record;
		logic       record_ok;
	} out_req_t;

endpackage

// File: sv/transport_counter_restamper.sv
// ----------------------------------------------------------------------------
// transport_counter_restamper
// rewrites the counter field of each well formed frame header in a record
// ----------------------------------------------------------------------------
// Takes one record byte per request and returns one byte per request, in
// order. Each frame header is a 16-bit little-endian length followed by a
// 16-bit counter; for every frame whose header is complete, whose length is
// nonzero and whose payload fits in the record, the counter bytes are replaced
// by a running 16-bit frame counter (low byte first), which wraps and is
// cleared by new_session on the first byte of a record. On the last byte,
// record_ok reports whether the whole record was well formed; a malformed
// record must be dropped downstream. Throughput is one byte per clock while the
// output accepts; each byte passes the input register and then the result
// register, and the frame walk is combinational offset compares and counter
// update between them. Back-pressure on the output stalls the input register
// only once the result register is full. No clearing pass follows reset.
`timescale 1ns / 1ps

module transport_counter_restamper (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tcr_pkg::in_req_t in_req,
	output logic             out_valid,
	input  logic             out_ready,
	output tcr_pkg::out_req_t out_req
);

	// input register
	logic             valid_s1;
	tcr_pkg::in_req_t req_s1;

	// result register
	logic              valid_s2;
	tcr_pkg::out_req_t req_s2;

	// frame walk state
	logic [15:0] frame_counter_q;
	logic [8:0]  byte_offset_q;
	logic [8:0]  held_length_q;
	logic [2:0]  header_position_q;
	logic [7:0]  length_low_byte_q;
	logic [15:0] payload_remaining_q;
	logic        stamp_active_q;
	logic        error_seen_q;

	// next state of the walk
	logic [15:0] n_frame_counter;
	logic [8:0]  n_byte_offset;
	logic [8:0]  n_held_length;
	logic [2:0]  n_header_position;
	logic [7:0]  n_length_low_byte;
	logic [15:0] n_payload_remaining;
	logic        n_stamp_active;
	logic        n_error_seen;
	tcr_pkg::out_req_t n_out;

	logic        advance;
	logic [8:0]  pos;
	logic [15:0] dlc;

	// the request in s1 moves on when the result register is free or drains
	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = valid_s2;
	assign out_req   = req_s2;

	always_comb begin
		n_frame_counter     = frame_counter_q;
		n_byte_offset       = byte_offset_q;
		n_held_length       = held_length_q;
		n_header_position   = header_position_q;
		n_length_low_byte   = length_low_byte_q;
		n_payload_remaining = payload_remaining_q;
		n_stamp_active      = stamp_active_q;
		n_error_seen        = error_seen_q;
		n_out.out_byte      = req_s1.data_byte;
		n_out.end_of_record = req_s1.last_of_record;
		n_out.record_ok     = 1'b0;
		dlc                 = {req_s1.data_byte, length_low_byte_q};

		// first byte restarts the walk and samples the record length
		if (req_s1.first_of_record) begin
			if (req_s1.new_session) begin
				n_frame_counter = '0;
			end
			n_byte_offset       = '0;
			n_held_length       = req_s1.record_length;
			n_header_position   = tcr_pkg::HDR_LEN_LO;
			n_length_low_byte   = '0;
			n_payload_remaining = '0;
			n_stamp_active      = 1'b0;
			n_error_seen        = (req_s1.record_length == 9'd0)
				|| (32'(req_s1.record_length) > tcr_pkg::MAX_RECORD_BYTES);
		end

		pos = n_byte_offset;

		if (pos >= n_held_length) begin
			// byte beyond the sampled length
			n_error_seen   = 1'b1;
			n_stamp_active = 1'b0;
		end else if (!n_error_seen) begin
			unique case (n_header_position)
				tcr_pkg::HDR_LEN_LO: begin
					// a header must fit before the record ends
					if ({1'b0, pos} + tcr_pkg::HDR_BYTES > {1'b0, n_held_length}) begin
						n_error_seen   = 1'b1;
						n_stamp_active = 1'b0;
					end else begin
						n_length_low_byte = req_s1.data_byte;
						n_header_position = tcr_pkg::HDR_LEN_HI;
					end
				end
				tcr_pkg::HDR_LEN_HI: begin
					// frame starts one byte back and must end inside the record
					dlc = {req_s1.data_byte, n_length_low_byte};
					if (dlc == 16'd0 || ({8'd0, pos} + 17'd3 + {1'b0, dlc})
							> {8'd0, n_held_length}) begin
						n_error_seen   = 1'b1;
						n_stamp_active = 1'b0;
					end else begin
						n_payload_remaining = dlc;
						n_stamp_active      = 1'b1;
						n_header_position   = tcr_pkg::HDR_CNT_LO;
					end
				end
				tcr_pkg::HDR_CNT_LO: begin
					if (n_stamp_active) begin
						n_out.out_byte = n_frame_counter[7:0];
					end
					n_header_position = tcr_pkg::HDR_CNT_HI;
				end
				tcr_pkg::HDR_CNT_HI: begin
					if (n_stamp_active) begin
						n_out.out_byte  = n_frame_counter[15:8];
						n_frame_counter = n_frame_counter + 16'd1;
					end
					n_stamp_active    = 1'b0;
					n_header_position = tcr_pkg::HDR_PAYLOAD;
				end
				default: begin
					// payload bytes count down to the next header
					if (n_payload_remaining != 16'd0) begin
						n_payload_remaining = n_payload_remaining - 16'd1;
					end
					if (n_payload_remaining == 16'd0) begin
						n_header_position = tcr_pkg::HDR_LEN_LO;
					end
				end
			endcase
		end

		n_byte_offset = (pos != tcr_pkg::OFFSET_MAX) ? pos + 9'd1 : pos;

		// last mark must fall on the final byte, with no frame left open
		if (req_s1.last_of_record) begin
			if ({1'b0, pos} + 10'd1 != {1'b0, n_held_length}) begin
				n_error_seen   = 1'b1;
				n_stamp_active = 1'b0;
			end
			n_out.record_ok = !n_error_seen && (n_header_position == tcr_pkg::HDR_LEN_LO);
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_req;
		end
		if (advance) begin
			req_s2 <= n_out;
		end
	end

	// walk state advances once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_counter_q     <= '0;
			byte_offset_q       <= '0;
			held_length_q       <= '0;
			header_position_q   <= tcr_pkg::HDR_LEN_LO;
			length_low_byte_q   <= '0;
			payload_remaining_q <= '0;
			stamp_active_q      <= 1'b0;
			error_seen_q        <= 1'b0;
		end else if (advance) begin
			frame_counter_q     <= n_frame_counter;
			byte_offset_q       <= n_byte_offset;
			held_length_q       <= n_held_length;
			header_position_q   <= n_header_position;
			length_low_byte_q   <= n_length_low_byte;
			payload_remaining_q <= n_payload_remaining;
			stamp_active_q      <= n_stamp_active;
			error_seen_q        <= n_error_seen;
		end
	end

endmodule

// File: sv/tcr_checker.sv
// ----------------------------------------------------------------------------
// tcr_checker
// port level checks of the transport counter restamper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "transport_counter_restamper_macros.svh"

module tcr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input tcr_pkg::in_req_t  in_req,
	input logic              out_valid,
	input logic              out_ready,
	input tcr_pkg::out_req_t out_req
);

	// a stalled result holds
	`TCR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_req))

	// ok is only reported on the closing byte
	`TCR_ASSERT_SAME(a_ok_at_end, clk, arst_n, out_valid && out_req.record_ok, out_req.end_of_record)

	// with the output open, an accepted request passes the input and result registers to the output
	`TCR_ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && in_ready && out_ready) ##1 out_ready, out_valid)

	// a one byte record can never hold a frame header
	`TCR_ASSERT_NEXT(a_short_bad, clk, arst_n, (in_valid && in_ready && out_ready && in_req.first_of_record && in_req.last_of_record) ##1 out_ready, out_valid && !out_req.record_ok)

endmodule

bind transport_counter_restamper tcr_checker u_tcr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_req   (in_req),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_req  (out_req)
);
